[hdl/xpad_pkg.sv]
package xpad_pkg;

  localparam int MAX_INDICATORS = 4;

  localparam logic [4:0] APP_END       = 5'd0;
  localparam logic [4:0] APP_LENGTH    = 5'd1;
  localparam logic [4:0] APP_DL_START  = 5'd2;
  localparam logic [4:0] APP_DL_CONT   = 5'd3;
  localparam logic [4:0] APP_MSC_START = 5'd12;
  localparam logic [4:0] APP_MSC_CONT  = 5'd13;

  localparam logic [1:0] FPAD_TYPE_0   = 2'd0;
  localparam logic [1:0] XPAD_VARIABLE = 2'd2;

  localparam logic [5:0] LENGTH_SUBFIELD_BYTES = 6'd4;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_CI   = 3'd1,
    MODE_LEN  = 3'd2,
    MODE_DATA = 3'd3,
    MODE_CONT = 3'd4
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] pad_byte;
    logic       field_start;
    logic       field_end;
    logic [7:0] fpad_upper;
    logic [7:0] fpad_lower;
  } xpad_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [4:0] app_type;
    logic       subfield_first;
    logic       subfield_last;
    logic       continuation;
    logic       group_complete;
  } xpad_out_t;

  function automatic logic [5:0] subfield_len(input logic [2:0] code);
    logic [5:0] len;
    case (code)
      3'd0: len = 6'd4;
      3'd1: len = 6'd6;
      3'd2: len = 6'd8;
      3'd3: len = 6'd12;
      3'd4: len = 6'd16;
      3'd5: len = 6'd24;
      3'd6: len = 6'd32;
      3'd7: len = 6'd48;
      default: len = 6'd4;
    endcase
    return len;
  endfunction

endpackage

[hdl/xpad_subfield_demux_unit.sv]
// Variable X-PAD subfield demultiplexer. Each request carries one X-PAD byte in
// transmission order, with the F-PAD bytes and field markers that go with it; each
// result is one payload byte tagged with its application type, subfield boundaries,
// continuation flag and MSC data group completion. Contents indicator bytes and bytes
// of fields that are not F-PAD type 0 with variable X-PAD give no result. The block
// takes one request per clock cycle while the result register is empty or being taken,
// and delivers its result in the cycle after: the whole parser state update is
// combinational logic, and a result register separates the two channels so that a
// stalled result only holds the input while it is not taken.
module xpad_subfield_demux_unit
  import xpad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  xpad_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output xpad_out_t out_data
);

  parse_mode_t mode_r, mode_nxt;
  logic [7:0]  tab_r [4];
  logic [7:0]  tab_nxt [4];
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic        gact_r, gact_nxt;
  logic [7:0]  fsize_r, fsize_nxt;
  logic        fsv_r, fsv_nxt;
  logic [13:0] glen_r, glen_nxt;
  logic [15:0] gfill_r, gfill_nxt;
  logic [5:0]  lhp_r, lhp_nxt;
  logic [7:0]  cont_left_r, cont_left_nxt;
  logic        sub_first_r, sub_first_nxt;

  logic        out_valid_r;
  xpad_out_t   out_r;
  logic        res_valid;
  xpad_out_t   res;
  logic        accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] ind;
    logic [4:0] app;
    logic       last;
    logic       done;
    logic       finish;
    logic       do_begin;

    mode_nxt      = mode_r;
    tab_nxt       = tab_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    gact_nxt      = gact_r;
    fsize_nxt     = fsize_r;
    fsv_nxt       = fsv_r;
    glen_nxt      = glen_r;
    gfill_nxt     = gfill_r;
    lhp_nxt       = lhp_r;
    cont_left_nxt = cont_left_r;
    sub_first_nxt = sub_first_r;
    res_valid     = 1'b0;
    res           = '0;
    b             = in_data.pad_byte;
    sum           = '0;
    ind           = '0;
    app           = '0;
    last          = 1'b0;
    done          = 1'b0;
    finish        = 1'b0;
    do_begin      = 1'b0;

    if (in_data.field_start) begin
      cnt_nxt = '0;
      pos_nxt = '0;
      if (in_data.fpad_upper[7:6] != FPAD_TYPE_0 ||
          in_data.fpad_upper[5:4] != XPAD_VARIABLE) begin
        mode_nxt = MODE_IDLE;
      end else if (in_data.fpad_lower[1]) begin
        mode_nxt = MODE_CI;
      end else if (gact_r && fsv_r && fsize_r != 8'd0) begin
        mode_nxt      = MODE_CONT;
        cont_left_nxt = fsize_r;
        sub_first_nxt = 1'b1;
      end else begin
        mode_nxt = MODE_IDLE;
      end
    end

    case (mode_nxt)
      MODE_CI: begin
        if (b[4:0] != APP_END && cnt_nxt < 3'(MAX_INDICATORS)) begin
          tab_nxt[cnt_nxt[1:0]] = b;
          cnt_nxt = cnt_nxt + 3'd1;
          if (cnt_nxt >= 3'(MAX_INDICATORS)) begin
            finish = 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
      end
      MODE_LEN, MODE_DATA: begin
        app = tab_nxt[pos_nxt[1:0]][4:0];
        if (mode_nxt == MODE_LEN) begin
          if (rem_nxt == LENGTH_SUBFIELD_BYTES) begin
            lhp_nxt = b[5:0];
          end else if (rem_nxt == LENGTH_SUBFIELD_BYTES - 6'd1) begin
            glen_nxt = {lhp_nxt, b};
          end
        end
        rem_nxt = rem_nxt - 6'd1;
        last    = (rem_nxt == 6'd0);
        if (app == APP_MSC_START) begin
          if (gfill_nxt != 16'hffff) begin
            gfill_nxt = gfill_nxt + 16'd1;
          end
          if (last) begin
            if (gfill_nxt >= {2'b00, glen_nxt}) begin
              done      = 1'b1;
              gact_nxt  = 1'b0;
              gfill_nxt = '0;
            end else begin
              gact_nxt = 1'b1;
            end
          end
        end else if (app == APP_MSC_CONT && gfill_nxt != 16'd0) begin
          if (gfill_nxt != 16'hffff) begin
            gfill_nxt = gfill_nxt + 16'd1;
          end
          if (last && gfill_nxt >= {2'b00, glen_nxt}) begin
            done      = 1'b1;
            gact_nxt  = 1'b0;
            gfill_nxt = '0;
          end
        end
        res_valid          = 1'b1;
        res.data_byte      = b;
        res.app_type       = app;
        res.subfield_first = sub_first_nxt;
        res.subfield_last  = last;
        res.continuation   = 1'b0;
        res.group_complete = done;
        sub_first_nxt      = 1'b0;
        if (last) begin
          pos_nxt  = pos_nxt + 3'd1;
          do_begin = 1'b1;
        end
      end
      MODE_CONT: begin
        cont_left_nxt = cont_left_nxt - 8'd1;
        last          = (cont_left_nxt == 8'd0);
        if (gfill_nxt != 16'd0) begin
          if (gfill_nxt != 16'hffff) begin
            gfill_nxt = gfill_nxt + 16'd1;
          end
          if (last && gfill_nxt >= {2'b00, glen_nxt}) begin
            done      = 1'b1;
            gact_nxt  = 1'b0;
            gfill_nxt = '0;
          end
        end
        res_valid          = 1'b1;
        res.data_byte      = b;
        res.app_type       = APP_MSC_CONT;
        res.subfield_first = sub_first_nxt;
        res.subfield_last  = last;
        res.continuation   = 1'b1;
        res.group_complete = done;
        sub_first_nxt      = 1'b0;
        if (last) begin
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (finish) begin
      if (gact_nxt) begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < cnt_nxt) begin
            sum = sum + {2'b00, subfield_len(tab_nxt[i][7:5])};
          end
        end
        if (cnt_nxt >= 3'(MAX_INDICATORS)) begin
          sum = sum + {5'd0, cnt_nxt};
        end else begin
          sum = sum + {5'd0, cnt_nxt} + 8'd1;
        end
        fsize_nxt = sum;
        fsv_nxt   = 1'b1;
      end
      pos_nxt  = '0;
      do_begin = 1'b1;
    end

    if (do_begin) begin
      if (pos_nxt >= cnt_nxt || pos_nxt >= 3'd4) begin
        mode_nxt = MODE_IDLE;
      end else begin
        ind           = tab_nxt[pos_nxt[1:0]];
        sub_first_nxt = 1'b1;
        if (ind[4:0] == APP_LENGTH) begin
          mode_nxt = MODE_LEN;
          rem_nxt  = LENGTH_SUBFIELD_BYTES;
        end else if (ind[4:0] == APP_DL_START || ind[4:0] == APP_DL_CONT ||
                     ind[4:0] == APP_MSC_START || ind[4:0] == APP_MSC_CONT) begin
          mode_nxt = MODE_DATA;
          rem_nxt  = subfield_len(ind[7:5]);
          if (ind[4:0] == APP_MSC_START) begin
            gfill_nxt = '0;
          end
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
    end

    if (in_data.field_end) begin
      mode_nxt = MODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      rem_r       <= '0;
      gact_r      <= 1'b0;
      fsize_r     <= '0;
      fsv_r       <= 1'b0;
      glen_r      <= '0;
      gfill_r     <= '0;
      lhp_r       <= '0;
      cont_left_r <= '0;
      sub_first_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r      <= mode_nxt;
        cnt_r       <= cnt_nxt;
        pos_r       <= pos_nxt;
        rem_r       <= rem_nxt;
        gact_r      <= gact_nxt;
        fsize_r     <= fsize_nxt;
        fsv_r       <= fsv_nxt;
        glen_r      <= glen_nxt;
        gfill_r     <= gfill_nxt;
        lhp_r       <= lhp_nxt;
        cont_left_r <= cont_left_nxt;
        sub_first_r <= sub_first_nxt;
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tab_r <= tab_nxt;
      if (res_valid) begin
        out_r <= res;
      end
    end
  end

  a_complete_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.group_complete |-> out_r.subfield_last)
    else $error("group completion flagged on a byte that does not end a subfield");

  a_cont_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.continuation |-> out_r.app_type == APP_MSC_CONT)
    else $error("continuation byte carries the wrong application type");

  a_cont_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_CONT |-> cont_left_r != 8'd0)
    else $error("continuation field active with no bytes left");

  a_subfield_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_LEN || mode_r == MODE_DATA) |-> rem_r != 6'd0 && pos_r < cnt_r)
    else $error("subfield active beyond its length or its indicator list");

endmodule
